[rtl/core/hdip_pkg.sv]
// hdip_pkg: shared types and constants for the hid descriptor item parser
// no dependencies
package hdip_pkg;

  typedef enum logic [2:0] {
    CLS_UNDECIDED   = 3'd0,
    CLS_MOUSE       = 3'd1,
    CLS_KEYBOARD    = 3'd2,
    CLS_UNSUPPORTED = 3'd3,
    CLS_INVALID     = 3'd4
  } class_t;

  localparam logic [1:0] TYPE_GLOBAL   = 2'd1;
  localparam logic [1:0] TYPE_LOCAL    = 2'd2;
  localparam logic [7:0] TAG_USAGE     = 8'd0;
  localparam logic [7:0] TAG_LONG      = 8'd15;
  localparam logic [1:0] SIZE_CODE_4   = 2'd3;
  localparam logic [31:0] PAGE_DESKTOP = 32'd1;
  localparam logic [31:0] USAGE_MOUSE  = 32'd2;
  localparam logic [31:0] USAGE_KBD    = 32'd6;

  typedef struct packed {
    class_t      class_status;
    logic        item_truncated;
    logic [31:0] item_data;
    logic [7:0]  item_size;
    logic [7:0]  item_tag;
    logic [1:0]  item_type;
    logic        item_format;
  } item_t;

endpackage

[rtl/core/hid_descriptor_item_parser_top.sv]
// hid_descriptor_item_parser_top: splits a hid report descriptor into items
// and classifies the device from the first two items; depends on hdip_pkg
//
//   channel   dir  tdata                                   tlast
//   s_axis    in   desc_byte[7:0]                          last_byte
//   m_axis    out  item fields, 56 bits (see port comment) descriptor_end
//
// one byte is taken every cycle unless a stalled result holds the input; each
// byte is held in the input register, and its item result, if any, is then registered in the output register
// rst clears parser phase, item count and class; phase, item count and class
// also return to their reset values after each descriptor's final byte
// a stalled result holds the input register, which in turn drops s_axis_tready
module hid_descriptor_item_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // desc_byte[7:0]
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // item_format[0], item_type[2:1], item_tag[10:3], item_size[18:11],
  // item_data[50:19], item_truncated[51], class_status[54:52], zero[55]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast    // descriptor_end
);

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_LSIZE  = 3'd1,
    PH_LTAG   = 3'd2,
    PH_LSKIP  = 3'd3,
    PH_SDATA  = 3'd4
  } phase_t;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // parser state
  phase_t         parse_phase, parse_phase_next;
  logic [7:0]     bytes_left, bytes_left_next;
  logic [1:0]     data_index, data_index_next;
  logic [31:0]    data_accum, data_accum_next;
  logic [1:0]     held_type, held_type_next;
  logic [7:0]     held_tag, held_tag_next;
  logic [7:0]     held_size, held_size_next;
  logic           held_long, held_long_next;
  logic [1:0]     items_seen, items_seen_next;
  hdip_pkg::class_t class_state, class_state_next;

  // result register
  hdip_pkg::item_t out_item;
  logic            out_last;

  logic             out_free;
  logic             step;
  logic             emit;
  logic             trunc;
  hdip_pkg::class_t cls;
  hdip_pkg::item_t  item_next;
  logic             first_ok;
  logic             second_form;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_comb begin
    parse_phase_next = parse_phase;
    bytes_left_next  = bytes_left;
    data_index_next  = data_index;
    data_accum_next  = data_accum;
    held_type_next   = held_type;
    held_tag_next    = held_tag;
    held_size_next   = held_size;
    held_long_next   = held_long;
    items_seen_next  = items_seen;
    class_state_next = class_state;
    emit             = 1'b0;
    trunc            = 1'b0;

    unique case (parse_phase)
      PH_LSIZE: begin
        held_size_next   = in_byte;
        parse_phase_next = PH_LTAG;
      end
      PH_LTAG: begin
        held_tag_next    = in_byte;
        bytes_left_next  = held_size;
        parse_phase_next = PH_LSKIP;
        emit             = (held_size == 8'd0);
      end
      PH_LSKIP: begin
        bytes_left_next = bytes_left - 8'd1;
        emit            = (bytes_left_next == 8'd0);
      end
      PH_SDATA: begin
        unique case (data_index)
          2'd0: data_accum_next = data_accum | {24'd0, in_byte};
          2'd1: data_accum_next = data_accum | {16'd0, in_byte, 8'd0};
          2'd2: data_accum_next = data_accum | {8'd0, in_byte, 16'd0};
          default: data_accum_next = data_accum | {in_byte, 24'd0};
        endcase
        data_index_next = data_index + 2'd1;
        bytes_left_next = bytes_left - 8'd1;
        emit            = (bytes_left_next == 8'd0);
      end
      default: begin
        held_type_next  = in_byte[3:2];
        held_tag_next   = {4'd0, in_byte[7:4]};
        data_accum_next = 32'd0;
        data_index_next = 2'd0;
        if (in_byte[7:4] == hdip_pkg::TAG_LONG[3:0]) begin
          held_long_next   = 1'b1;
          held_size_next   = 8'd0;
          parse_phase_next = PH_LSIZE;
        end else begin
          held_long_next   = 1'b0;
          held_size_next   = (in_byte[1:0] == hdip_pkg::SIZE_CODE_4) ? 8'd4
                                                                      : {6'd0, in_byte[1:0]};
          bytes_left_next  = held_size_next;
          parse_phase_next = PH_SDATA;
          emit             = (held_size_next == 8'd0);
        end
      end
    endcase

    if (!emit && in_last) begin
      emit  = 1'b1;
      trunc = 1'b1;
    end

    first_ok = !held_long_next && held_size_next == 8'd1 &&
               held_type_next == hdip_pkg::TYPE_GLOBAL &&
               held_tag_next == hdip_pkg::TAG_USAGE &&
               data_accum_next == hdip_pkg::PAGE_DESKTOP;
    second_form = !held_long_next && held_size_next == 8'd1 &&
                  held_type_next == hdip_pkg::TYPE_LOCAL &&
                  held_tag_next == hdip_pkg::TAG_USAGE;

    cls = class_state;
    if (class_state == hdip_pkg::CLS_UNDECIDED) begin
      if (items_seen == 2'd0) begin
        if (trunc || in_last || !first_ok) cls = hdip_pkg::CLS_INVALID;
      end else if (items_seen == 2'd1) begin
        priority if (trunc || !second_form) cls = hdip_pkg::CLS_INVALID;
        else if (data_accum_next == hdip_pkg::USAGE_MOUSE) cls = hdip_pkg::CLS_MOUSE;
        else if (data_accum_next == hdip_pkg::USAGE_KBD) cls = hdip_pkg::CLS_KEYBOARD;
        else cls = hdip_pkg::CLS_UNSUPPORTED;
      end
    end

    item_next.item_format    = held_long_next;
    item_next.item_type      = held_type_next;
    item_next.item_tag       = held_tag_next;
    item_next.item_size      = held_size_next;
    item_next.item_data      = held_long_next ? 32'd0 : data_accum_next;
    item_next.item_truncated = trunc;
    item_next.class_status   = cls;

    if (emit) begin
      class_state_next = cls;
      if (items_seen != 2'd3) items_seen_next = items_seen + 2'd1;
      parse_phase_next = PH_PREFIX;
      bytes_left_next  = 8'd0;
      data_index_next  = 2'd0;
      if (in_last) begin
        items_seen_next  = 2'd0;
        class_state_next = hdip_pkg::CLS_UNDECIDED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (step && emit) begin
      out_item <= item_next;
      out_last <= in_last;
    end
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      parse_phase   <= PH_PREFIX;
      bytes_left    <= 8'd0;
      data_index    <= 2'd0;
      items_seen    <= 2'd0;
      class_state   <= hdip_pkg::CLS_UNDECIDED;
      data_accum    <= 32'd0;
      held_type     <= 2'd0;
      held_tag      <= 8'd0;
      held_size     <= 8'd0;
      held_long     <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (step) begin
        parse_phase <= parse_phase_next;
        bytes_left  <= bytes_left_next;
        data_index  <= data_index_next;
        items_seen  <= items_seen_next;
        class_state <= class_state_next;
        data_accum  <= data_accum_next;
        held_type   <= held_type_next;
        held_tag    <= held_tag_next;
        held_size   <= held_size_next;
        held_long   <= held_long_next;
      end
      if (out_free) m_axis_tvalid <= step && emit;
    end
  end

  assign m_axis_tdata = {1'b0, out_item};
  assign m_axis_tlast = out_last;

endmodule
